// File: hdl/cacc_pkg.sv
// Shared types, constants and fixed-point helpers for the spacing controller.
// Used by every module of the block; depends on nothing.
package cacc_pkg;

    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [16:0] KF_Q      = 17'd655;
    localparam logic [18:0] KF_R      = 19'd196608;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic signed [18:0] MAX_ACCEL = 19'sd239704;

    localparam logic [CFG_W-1:0] KP_RESET  = 31'd43254;
    localparam logic [CFG_W-1:0] KD_RESET  = 31'd45875;
    localparam logic [CFG_W-1:0] HW_RESET  = 31'd13107;
    localparam logic [CFG_W-1:0] SD_RESET  = 31'd199754;
    localparam logic [CFG_W-1:0] DT_RESET  = 31'd6554;

    localparam logic [2:0] MODE_ACC      = 3'd0;
    localparam logic [2:0] MODE_LOCAL_DU = 3'd2;
    localparam logic [2:0] MODE_LOCAL_RU = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 3'd0,
        CFG_KD       = 3'd1,
        CFG_HEADWAY  = 3'd2,
        CFG_STANDST  = 3'd3,
        CFG_INTERVAL = 3'd4,
        CFG_CRUISE   = 3'd5,
        CFG_BACKUP   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        STEP_NONE    = 4'd0,
        STEP_CAPTURE = 4'd1,
        STEP_GAIN    = 4'd2,
        STEP_EST     = 4'd3,
        STEP_VAR     = 4'd4,
        STEP_ERR     = 4'd5,
        STEP_RATE    = 4'd6,
        STEP_PTERM   = 4'd7,
        STEP_SUM     = 4'd8,
        STEP_ACCDIV  = 4'd9,
        STEP_OUT     = 4'd10
    } t_step;

    typedef struct packed {
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_dp_status;

    typedef struct packed {
        logic [30:0]        measured_gap;
        logic signed [31:0] own_speed;
        logic signed [31:0] own_accel;
        logic signed [31:0] lead_accel_comm;
        logic signed [31:0] lead_accel_approach;
        logic signed [31:0] lead_accel_local;
        logic               link_lost;
    } t_in_item;

    typedef struct packed {
        logic signed [18:0] commanded_accel;
        logic signed [31:0] filtered_gap;
        logic signed [31:0] spacing_error;
    } t_out_item;

    // Q16.16 product scaled back by 2^16, rounding toward zero.
    function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? 64'sd65535 : 64'sd0);
        return $signed(t[63:16]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/cacc_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
// The payload type is given by the instantiating level (types from cacc_pkg).
interface cacc_stream_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hdl/cacc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cacc_pkg for its widths; the divisor must be nonzero.
module cacc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cacc_pkg::DIV_NUM_W-1:0]    i_dividend,
    input  logic [cacc_pkg::DIV_DEN_W-1:0]    i_divisor,
    output logic [cacc_pkg::DIV_NUM_W-1:0]    o_quotient,
    output logic                              o_busy,
    output logic                              o_done
);
    logic [cacc_pkg::DIV_NUM_W-1:0] r_num;
    logic [cacc_pkg::DIV_DEN_W-1:0] r_rem;
    logic [cacc_pkg::DIV_DEN_W-1:0] r_den;
    logic [cacc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [cacc_pkg::DIV_DEN_W:0]   rem_sh;
    logic [cacc_pkg::DIV_DEN_W+1:0] diff;
    logic                           ge;

    always_comb begin
        rem_sh = {r_rem, r_num[cacc_pkg::DIV_NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = !diff[cacc_pkg::DIV_DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits its register.
            r_rem <= ge ? diff[cacc_pkg::DIV_DEN_W-1:0] : rem_sh[cacc_pkg::DIV_DEN_W-1:0];
            r_num <= {r_num[cacc_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cacc_pkg::DIV_CNT_W'(cacc_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_num;
    assign o_busy     = r_busy;
    assign o_done     = r_done;
endmodule

// File: hdl/cacc_datapath.sv
// Datapath: configuration registers, filter and error state, shared multiplier
// and divider. Steps are chosen by cacc_ctrl; depends on cacc_pkg and cacc_div.
module cacc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cacc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cacc_pkg::CFG_W-1:0]        i_cfg_data,
    input  cacc_pkg::t_in_item                i_item,
    input  cacc_pkg::t_dp_cmd                 i_cmd,
    output cacc_pkg::t_dp_status              o_status,
    output cacc_pkg::t_out_item               o_item
);
    logic [cacc_pkg::CFG_W-1:0] r_kp, r_kd, r_hw, r_sd, r_dt;
    logic [2:0]                 r_cmode, r_bmode;

    cacc_pkg::t_in_item  r_in;
    cacc_pkg::t_out_item r_out;
    logic signed [31:0]  r_x;
    logic [16:0]         r_var;
    logic [16:0]         r_pp;
    logic [15:0]         r_g;
    logic signed [31:0]  r_err;
    logic signed [31:0]  r_prev;
    logic signed [31:0]  r_derr;
    logic signed [47:0]  r_acc1;
    logic signed [63:0]  r_prod;
    logic                r_neg;

    logic [cacc_pkg::CFG_W-1:0] hw_eff, dt_eff;
    logic [16:0]         pp_c;
    logic [18:0]         kden_c;
    logic signed [48:0]  desired_c;
    logic signed [31:0]  err_c;
    logic signed [32:0]  de_c;
    logic [32:0]         de_mag;
    logic signed [50:0]  rate_c;
    logic signed [32:0]  alead_c;
    logic [2:0]          mode_c;
    logic signed [50:0]  sum_w;
    logic signed [31:0]  sum_c;
    logic [63:0]         prod_mag;
    logic signed [64:0]  q_s;
    logic signed [64:0]  acc_w;
    logic signed [18:0]  acc_c;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic                mul_en;

    logic                             div_start;
    logic [cacc_pkg::DIV_NUM_W-1:0]   div_num;
    logic [cacc_pkg::DIV_DEN_W-1:0]   div_den;
    logic [cacc_pkg::DIV_NUM_W-1:0]   div_q;
    logic                             div_busy, div_done;

    function automatic logic signed [47:0] trunc_p();
        return cacc_pkg::trunc16(r_prod);
    endfunction

    function automatic logic signed [31:0] r_prod_lo32();
        return 32'(cacc_pkg::trunc16(r_prod));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= cacc_pkg::KP_RESET;
            r_kd    <= cacc_pkg::KD_RESET;
            r_hw    <= cacc_pkg::HW_RESET;
            r_sd    <= cacc_pkg::SD_RESET;
            r_dt    <= cacc_pkg::DT_RESET;
            r_cmode <= cacc_pkg::MODE_ACC;
            r_bmode <= cacc_pkg::MODE_ACC;
        end else if (i_cfg_we) begin
            unique case (cacc_pkg::t_cfg_idx'(i_cfg_idx))
                cacc_pkg::CFG_KP:       r_kp    <= i_cfg_data;
                cacc_pkg::CFG_KD:       r_kd    <= i_cfg_data;
                cacc_pkg::CFG_HEADWAY:  r_hw    <= i_cfg_data;
                cacc_pkg::CFG_STANDST:  r_sd    <= i_cfg_data;
                cacc_pkg::CFG_INTERVAL: r_dt    <= i_cfg_data;
                cacc_pkg::CFG_CRUISE:   r_cmode <= i_cfg_data[2:0];
                cacc_pkg::CFG_BACKUP:   r_bmode <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // A zero headway or interval acts as the smallest nonzero value.
        hw_eff = (r_hw == '0) ? cacc_pkg::CFG_W'(1) : r_hw;
        dt_eff = (r_dt == '0) ? cacc_pkg::CFG_W'(1) : r_dt;

        pp_c   = r_var + cacc_pkg::KF_Q;
        kden_c = {2'b00, pp_c} + cacc_pkg::KF_R;

        desired_c = $signed({18'b0, r_sd}) + 49'(trunc_p());
        err_c     = cacc_pkg::sat32(64'($signed({{18{r_x[31]}}, r_x}) - 50'(desired_c)));
        de_c      = 33'(err_c) - 33'(r_prev);
        de_mag    = de_c[32] ? 33'(-de_c) : 33'(de_c);

        rate_c = r_neg ? -$signed({1'b0, div_q[49:0]}) : $signed({1'b0, div_q[49:0]});

        mode_c = r_in.link_lost ? r_bmode : r_cmode;
        if (mode_c == cacc_pkg::MODE_LOCAL_DU) begin
            alead_c = 33'($signed(r_in.own_accel)) + 33'($signed(r_in.lead_accel_approach));
        end else if (mode_c == cacc_pkg::MODE_LOCAL_RU) begin
            alead_c = 33'($signed(r_in.lead_accel_local));
        end else begin
            alead_c = 33'($signed(r_in.lead_accel_comm));
        end
        sum_w = 51'(r_acc1) + 51'(trunc_p()) + 51'(alead_c)
              - 51'($signed(r_in.own_accel));
        sum_c = cacc_pkg::sat32(64'(sum_w));

        prod_mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);

        q_s   = r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        acc_w = q_s + 65'($signed(r_in.own_accel));
        if (acc_w > 65'(cacc_pkg::MAX_ACCEL)) begin
            acc_c = cacc_pkg::MAX_ACCEL;
        end else if (acc_w < -65'(cacc_pkg::MAX_ACCEL)) begin
            acc_c = -cacc_pkg::MAX_ACCEL;
        end else begin
            acc_c = acc_w[18:0];
        end
    end

    // Operand selection for the shared multiplier and divider.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (i_cmd.step)
            cacc_pkg::STEP_CAPTURE: begin
                div_start = 1'b1;
                div_num   = cacc_pkg::DIV_NUM_W'({pp_c, 16'b0});
                div_den   = cacc_pkg::DIV_DEN_W'(kden_c);
            end
            cacc_pkg::STEP_GAIN: begin
                mul_en = 1'b1;
                mul_a  = $signed({17'b0, div_q[15:0]});
                mul_b  = $signed({2'b00, r_in.measured_gap}) - 33'(r_x);
            end
            cacc_pkg::STEP_EST: begin
                mul_en = 1'b1;
                mul_a  = $signed({16'b0, 17'(cacc_pkg::ONE_Q16 - {1'b0, r_g})});
                mul_b  = $signed({16'b0, r_pp});
            end
            cacc_pkg::STEP_VAR: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, hw_eff});
                mul_b  = 33'($signed(r_in.own_speed));
            end
            cacc_pkg::STEP_ERR: begin
                div_start = 1'b1;
                div_num   = cacc_pkg::DIV_NUM_W'({de_mag, 16'b0});
                div_den   = cacc_pkg::DIV_DEN_W'(dt_eff);
            end
            cacc_pkg::STEP_RATE: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, r_kp});
                mul_b  = 33'(r_err);
            end
            cacc_pkg::STEP_PTERM: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, r_kd});
                mul_b  = 33'(r_derr);
            end
            cacc_pkg::STEP_SUM: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, dt_eff});
                mul_b  = 33'(sum_c);
            end
            cacc_pkg::STEP_ACCDIV: begin
                div_start = 1'b1;
                div_num   = prod_mag;
                div_den   = cacc_pkg::DIV_DEN_W'(hw_eff);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_var  <= cacc_pkg::ONE_Q16;
            r_prev <= '0;
        end else begin
            unique case (i_cmd.step)
                cacc_pkg::STEP_EST: r_x   <= r_x + r_prod_lo32();
                cacc_pkg::STEP_VAR: r_var <= 17'(cacc_pkg::trunc16(r_prod));
                cacc_pkg::STEP_ERR: r_prev <= err_c;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            cacc_pkg::STEP_CAPTURE: begin
                r_in <= i_item;
                r_pp <= pp_c;
            end
            cacc_pkg::STEP_GAIN:   r_g    <= div_q[15:0];
            cacc_pkg::STEP_ERR: begin
                r_err <= err_c;
                r_neg <= de_c[32];
            end
            cacc_pkg::STEP_RATE:   r_derr <= cacc_pkg::sat32(64'(rate_c));
            cacc_pkg::STEP_PTERM:  r_acc1 <= trunc_p();
            cacc_pkg::STEP_ACCDIV: r_neg  <= r_prod[63];
            cacc_pkg::STEP_OUT: begin
                r_out.commanded_accel <= acc_c;
                r_out.filtered_gap    <= r_x;
                r_out.spacing_error   <= r_err;
            end
            default: ;
        endcase
    end

    cacc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (div_q),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    assign o_status.div_busy = div_busy;
    assign o_status.div_done = div_done;
    assign o_item            = r_out;
endmodule

// File: hdl/cacc_ctrl.sv
// Controller: sequences one control tick through the datapath steps and owns
// the handshake flags of both channels. Depends on cacc_pkg.
module cacc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  cacc_pkg::t_dp_status  i_status,
    output cacc_pkg::t_dp_cmd     o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_WAIT_G = 11'b000_0000_0010,
        S_EST    = 11'b000_0000_0100,
        S_VAR    = 11'b000_0000_1000,
        S_ERR    = 11'b000_0001_0000,
        S_WAIT_R = 11'b000_0010_0000,
        S_PTERM  = 11'b000_0100_0000,
        S_SUM    = 11'b000_1000_0000,
        S_ADIV   = 11'b001_0000_0000,
        S_WAIT_A = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.step  = cacc_pkg::STEP_NONE;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = cacc_pkg::STEP_CAPTURE;
                    n_state    = S_WAIT_G;
                end
            end
            S_WAIT_G: begin
                if (i_status.div_done) begin
                    o_cmd.step = cacc_pkg::STEP_GAIN;
                    n_state    = S_EST;
                end
            end
            S_EST: begin
                o_cmd.step = cacc_pkg::STEP_EST;
                n_state    = S_VAR;
            end
            S_VAR: begin
                o_cmd.step = cacc_pkg::STEP_VAR;
                n_state    = S_ERR;
            end
            S_ERR: begin
                o_cmd.step = cacc_pkg::STEP_ERR;
                n_state    = S_WAIT_R;
            end
            S_WAIT_R: begin
                if (i_status.div_done) begin
                    o_cmd.step = cacc_pkg::STEP_RATE;
                    n_state    = S_PTERM;
                end
            end
            S_PTERM: begin
                o_cmd.step = cacc_pkg::STEP_PTERM;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.step = cacc_pkg::STEP_SUM;
                n_state    = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.step = cacc_pkg::STEP_ACCDIV;
                n_state    = S_WAIT_A;
            end
            S_WAIT_A: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // The quotient stays in the divider until the result register frees up.
                if (out_free) begin
                    o_cmd.step  = cacc_pkg::STEP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// File: hdl/cacc_spacing_controller.sv
// Spacing controller top level: Kalman-filtered gap, PD plus feedforward command.
// One item at a time: a new input is taken only after the last result has gone to the
// output register; each item makes three passes through the shared radix-2 divider.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset restores the register defaults, sets the gap
// estimate and previous error to zero and the gap variance to one.
module cacc_spacing_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cacc_stream_if.sink                    i_in,
    cacc_stream_if.source                  o_out,
    input  logic                           i_cfg_we,
    input  logic [cacc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cacc_pkg::CFG_W-1:0]     i_cfg_data
);
    cacc_pkg::t_dp_cmd    dp_cmd;
    cacc_pkg::t_dp_status dp_status;
    cacc_pkg::t_out_item  dp_out;
    logic                 in_ready;
    logic                 out_valid;

    cacc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    cacc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_item     (dp_out)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = dp_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("input taken again right after a transfer");

    a_accel_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (($signed(dp_out.commanded_accel) <= cacc_pkg::MAX_ACCEL) &&
                       ($signed(dp_out.commanded_accel) >= -cacc_pkg::MAX_ACCEL)))
        else $error("commanded acceleration outside its limit");

    a_div_free_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((dp_cmd.step == cacc_pkg::STEP_CAPTURE) || (dp_cmd.step == cacc_pkg::STEP_ERR) ||
         (dp_cmd.step == cacc_pkg::STEP_ACCDIV)) |-> !dp_status.div_busy)
        else $error("divider restarted while busy");
`endif
endmodule

// File: tb/tb_cacc_spacing_checker.sv
// Checker for the spacing controller: follows every input transfer, result transfer
// and register write, predicts each result and compares it whole, showing each field.
// Depends on cacc_pkg for the item types, register indexes and reset values.
module tb_cacc_spacing_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  cacc_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  cacc_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_we,
    input  logic [cacc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cacc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam longint Q16 = 65536;

    // Shadow copy of the control registers and filter state.
    longint kp, kd, headway, standstill, interval;
    logic [2:0] cruise, backup;
    longint gap_est, gap_var, last_err;

    cacc_pkg::t_out_item expected_results[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // One control tick: filter the gap, then form the acceleration command.
    function automatic cacc_pkg::t_out_item control_tick(input cacc_pkg::t_in_item it);
        longint gap, speed, acur, hw, dt, pp, g, desired, err, derr, alead, sum, acc;
        logic [2:0] mode;
        cacc_pkg::t_out_item r;
        gap   = longint'(it.measured_gap);
        speed = longint'(it.own_speed);
        acur  = longint'(it.own_accel);
        hw    = (headway == 0) ? 1 : headway;
        dt    = (interval == 0) ? 1 : interval;

        pp      = gap_var + 655;
        g       = (pp * Q16) / (pp + 196608);
        gap_est = gap_est + (g * (gap - gap_est)) / Q16;
        gap_var = ((Q16 - g) * pp) / Q16;

        desired = standstill + (hw * speed) / Q16;
        err     = clamp32(gap_est - desired);
        derr    = clamp32(((err - last_err) * Q16) / dt);

        mode = it.link_lost ? backup : cruise;
        if (mode == cacc_pkg::MODE_LOCAL_DU) begin
            alead = acur + longint'(it.lead_accel_approach);
        end else if (mode == cacc_pkg::MODE_LOCAL_RU) begin
            alead = longint'(it.lead_accel_local);
        end else begin
            alead = longint'(it.lead_accel_comm);
        end

        sum = clamp32((kp * err) / Q16 + (kd * derr) / Q16 + alead - acur);
        acc = (dt * sum) / hw + acur;
        if (acc < -239704) acc = -239704;
        if (acc > 239704) acc = 239704;
        last_err = err;

        r.commanded_accel = acc[18:0];
        r.filtered_gap    = gap_est[31:0];
        r.spacing_error   = err[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cacc_pkg::t_out_item want;
        if (!i_rst_n) begin
            kp         <= longint'(cacc_pkg::KP_RESET);
            kd         <= longint'(cacc_pkg::KD_RESET);
            headway    <= longint'(cacc_pkg::HW_RESET);
            standstill <= longint'(cacc_pkg::SD_RESET);
            interval   <= longint'(cacc_pkg::DT_RESET);
            cruise     <= cacc_pkg::MODE_ACC;
            backup     <= cacc_pkg::MODE_ACC;
            gap_est    = 0;
            gap_var    = Q16;
            last_err   = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cacc_pkg::CFG_KP:       kp         <= longint'(i_cfg_data);
                    cacc_pkg::CFG_KD:       kd         <= longint'(i_cfg_data);
                    cacc_pkg::CFG_HEADWAY:  headway    <= longint'(i_cfg_data);
                    cacc_pkg::CFG_STANDST:  standstill <= longint'(i_cfg_data);
                    cacc_pkg::CFG_INTERVAL: interval   <= longint'(i_cfg_data);
                    cacc_pkg::CFG_CRUISE:   cruise     <= i_cfg_data[2:0];
                    cacc_pkg::CFG_BACKUP:   backup     <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(control_tick(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with none expected: %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch accel exp %0d act %0d", $time,
                                 want.commanded_accel, i_out_data.commanded_accel);
                        $display("%0t: mismatch gap exp %0d act %0d", $time,
                                 want.filtered_gap, i_out_data.filtered_gap);
                        $display("%0t: mismatch error exp %0d act %0d", $time,
                                 want.spacing_error, i_out_data.spacing_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// File: tb/tb_cacc_spacing_controller.sv
// Top of the spacing controller testbench: clock, reset, register phases and stimulus.
// Depends on cacc_pkg, cacc_stream_if, the block and tb_cacc_spacing_checker.
module tb_cacc_spacing_controller;

    localparam logic [cacc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [30:0] MAX31 = 31'h7FFFFFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [cacc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [cacc_pkg::CFG_W-1:0] i_cfg_data;
    int fail_count;
    int pending;
    int cycle_count;

    cacc_stream_if #(.T_DATA(cacc_pkg::t_in_item))  in_ch ();
    cacc_stream_if #(.T_DATA(cacc_pkg::t_out_item)) out_ch ();

    cacc_spacing_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tb_cacc_spacing_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cacc_spacing_controller test failed");
            $finish;
        end
    end

    // Receiver: random stalls, one calm stretch and one long hold-off that fills the block.
    initial begin
        int n;
        n = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            n++;
            if (n >= 60000 && n < 90000) begin
                out_ch.ready <= 1'b1;
            end else if (n >= 20000 && n < 23000) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 9);
            end
        end
    end

    int sent;

    task automatic send_item(input cacc_pkg::t_in_item it);
        // The sender is never idle for items 400 through 700.
        while ((sent < 400 || sent > 700) && $urandom_range(0, 99) < 9) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [cacc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cacc_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [30:0] kp, input logic [30:0] kd,
                            input logic [30:0] hw, input logic [30:0] sd,
                            input logic [30:0] dt, input logic [2:0] cm,
                            input logic [2:0] bm);
        wait_drained();
        write_reg(cacc_pkg::CFG_KP, kp);
        write_reg(cacc_pkg::CFG_KD, kd);
        write_reg(cacc_pkg::CFG_HEADWAY, hw);
        write_reg(cacc_pkg::CFG_STANDST, sd);
        write_reg(cacc_pkg::CFG_INTERVAL, dt);
        write_reg(cacc_pkg::CFG_CRUISE, {28'd0, cm});
        write_reg(cacc_pkg::CFG_BACKUP, {28'd0, bm});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE, cacc_pkg::CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] mostly_near(input int span);
        if ($urandom_range(0, 99) < 70) return $urandom_range(0, 2 * span) - span;
        return $urandom;
    endfunction

    function automatic cacc_pkg::t_in_item random_item();
        cacc_pkg::t_in_item it;
        it.measured_gap = ($urandom_range(0, 99) < 70) ? 31'($urandom_range(0, 150 << 16))
                                                       : 31'($urandom);
        it.own_speed           = mostly_near(40 << 16);
        it.own_accel           = mostly_near(5 << 16);
        it.lead_accel_comm     = mostly_near(5 << 16);
        it.lead_accel_approach = mostly_near(5 << 16);
        it.lead_accel_local    = mostly_near(5 << 16);
        it.link_lost           = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic cacc_pkg::t_in_item make_item(input logic [30:0] gap,
                                                     input logic [31:0] spd,
                                                     input logic [31:0] acc,
                                                     input logic [31:0] la,
                                                     input logic lost);
        cacc_pkg::t_in_item it;
        it.measured_gap        = gap;
        it.own_speed           = spd;
        it.own_accel           = acc;
        it.lead_accel_comm     = la;
        it.lead_accel_approach = ~la;
        it.lead_accel_local    = la ^ 32'h5A5A5A5A;
        it.link_lost           = lost;
        return it;
    endfunction

    function automatic logic [30:0] random_gain(input int typical);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 31'd0;
        if (pick == 1) return MAX31;
        if (pick == 2) return 31'($urandom);
        return 31'($urandom_range(1, typical));
    endfunction

    initial begin
        cacc_pkg::t_in_item it;
        sent         = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = cacc_pkg::CFG_KP;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: field extremes, both link states.
        send_item(make_item(31'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        send_item(make_item(MAX31, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
        send_item(make_item(31'd0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
        send_item(make_item(MAX31, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1));
        send_item(make_item(31'd1310720, 32'd1966080, 32'd0, 32'hFFFF0000, 1'b0));
        send_item(make_item(31'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0));

        // Zero divisors, largest gains, local modes.
        set_regs(MAX31, MAX31, 31'd0, MAX31, 31'd0,
                 cacc_pkg::MODE_LOCAL_DU, cacc_pkg::MODE_LOCAL_RU);
        send_item(make_item(MAX31, 32'h80000000, 32'h7FFFFFFF, 32'h12345678, 1'b0));
        send_item(make_item(31'd0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b1));
        send_item(make_item(31'd655360, 32'd0, 32'h00010000, 32'h7FFFFFFF, 1'b0));
        send_item(make_item(MAX31, 32'hFFFFFFFF, 32'd1, 32'd0, 1'b1));

        // Zero gains, largest divisors, the unused mode codes.
        set_regs(31'd0, 31'd0, MAX31, 31'd0, MAX31, 3'd5, 3'd6);
        send_item(make_item(31'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0));
        send_item(make_item(MAX31, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1));
        set_regs(31'd43254, 31'd45875, 31'd1, 31'd199754, MAX31, 3'd7, 3'd1);
        send_item(make_item(MAX31, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0));
        send_item(make_item(31'd0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
        set_regs(31'd43254, 31'd45875, 31'd13107, 31'd199754, 31'd1, 3'd3, 3'd0);
        send_item(make_item(31'd2621440, 32'd1966080, 32'h00020000, 32'hFFFE0000, 1'b0));
        send_item(make_item(31'd0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1));

        for (int ph = 0; ph < 16; ph++) begin
            set_regs(random_gain(200000), random_gain(200000),
                     ($urandom_range(0, 7) == 0) ? random_gain(1) : 31'($urandom_range(1, 200000)),
                     random_gain(50 << 16),
                     ($urandom_range(0, 7) == 0) ? random_gain(1) : 31'($urandom_range(1, 30000)),
                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            for (int k = 0; k < 105; k++) begin
                it = random_item();
                send_item(it);
            end
        end

        wait_drained();
        repeat (220) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("cacc_spacing_controller test passed");
        end else begin
            $display("cacc_spacing_controller test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cacc_pkg.sv
hdl/cacc_stream_if.sv
hdl/cacc_div.sv
hdl/cacc_datapath.sv
hdl/cacc_ctrl.sv
hdl/cacc_spacing_controller.sv
tb/tb_cacc_spacing_checker.sv
tb/tb_cacc_spacing_controller.sv
